### hw/rtl/hcm_pkg.sv
// shared types, constants and arithmetic helpers for the 2x2 hill cipher, mod 63
// no dependencies
package hcm_pkg;

  localparam int MOD            = 63;
  localparam int CHAR_W         = 8;
  localparam int IDX_W          = 6;
  localparam int PROD_W         = 12;
  localparam int SUM_W          = 13;
  localparam int STATUS_W       = 2;
  localparam int REG_IDX_W      = 2;
  localparam int QDEPTH_DEFAULT = 4;

  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_DIGIT_0 = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;

  localparam logic KIND_DECRYPT = 1'b1;

  localparam logic [REG_IDX_W-1:0] REG_KEY_CHAR_0 = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_KEY_CHAR_1 = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_KEY_CHAR_2 = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_KEY_CHAR_3 = 2'd3;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_BAD_CHAR = 2'd1,
    STATUS_BAD_KEY  = 2'd2
  } status_t;

  typedef logic [IDX_W-1:0] idx_t;

  typedef struct packed {
    logic            kind;
    logic            bad;
    idx_t [3:0]      p;
  } item_t;

  typedef struct packed {
    idx_t [3:0]      k;
    idx_t [3:0]      minv;
    logic            kbad;
    logic            kinv_bad;
  } key_t;

  // returns {bad, index}
  function automatic logic [IDX_W:0] char_index(logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] d;
    logic              bad;
    bad = 1'b0;
    d   = '0;
    if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_A + 8'd25) begin
      d = c - CHAR_LOWER_A;
    end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_A + 8'd25) begin
      d = c - CHAR_UPPER_A + 8'd26;
    end else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_0 + 8'd9) begin
      d = c - CHAR_DIGIT_0 + 8'd52;
    end else if (c == CHAR_SPACE) begin
      d = 8'd62;
    end else begin
      bad = 1'b1;
    end
    return {bad, d[IDX_W-1:0]};
  endfunction

  function automatic logic [CHAR_W-1:0] index_char(idx_t i);
    logic [CHAR_W-1:0] w;
    w = {2'b00, i};
    if (i < 6'd26) begin
      return w + CHAR_LOWER_A;
    end else if (i < 6'd52) begin
      return w - 8'd26 + CHAR_UPPER_A;
    end else if (i < 6'd62) begin
      return w - 8'd52 + CHAR_DIGIT_0;
    end else begin
      return CHAR_SPACE;
    end
  endfunction

  // 64 is 1 mod 63, so fold 6-bit digits
  function automatic idx_t mod63(logic [SUM_W-1:0] x);
    logic [6:0] a;
    logic [6:0] b;
    a = {1'b0, x[5:0]} + {1'b0, x[11:6]} + {6'd0, x[12]};
    b = {1'b0, a[5:0]} + {6'd0, a[6]};
    if (b >= 7'(MOD)) begin
      b = b - 7'(MOD);
    end
    return b[IDX_W-1:0];
  endfunction

  function automatic idx_t mulmod(idx_t a, idx_t b);
    logic [PROD_W-1:0] p;
    p = PROD_W'(a) * PROD_W'(b);
    return mod63({1'b0, p});
  endfunction

  function automatic idx_t neg63(idx_t k);
    return (k == '0) ? '0 : (IDX_W'(MOD) - k);
  endfunction

  // multiplicative inverse mod 63, zero where none exists
  function automatic idx_t inv63(idx_t d);
    case (d)
      6'd1:    return 6'd1;
      6'd2:    return 6'd32;
      6'd4:    return 6'd16;
      6'd5:    return 6'd38;
      6'd8:    return 6'd8;
      6'd10:   return 6'd19;
      6'd11:   return 6'd23;
      6'd13:   return 6'd34;
      6'd16:   return 6'd4;
      6'd17:   return 6'd26;
      6'd19:   return 6'd10;
      6'd20:   return 6'd41;
      6'd22:   return 6'd43;
      6'd23:   return 6'd11;
      6'd25:   return 6'd58;
      6'd26:   return 6'd17;
      6'd29:   return 6'd50;
      6'd31:   return 6'd61;
      6'd32:   return 6'd2;
      6'd34:   return 6'd13;
      6'd37:   return 6'd46;
      6'd38:   return 6'd5;
      6'd40:   return 6'd52;
      6'd41:   return 6'd20;
      6'd43:   return 6'd22;
      6'd44:   return 6'd53;
      6'd46:   return 6'd37;
      6'd47:   return 6'd59;
      6'd50:   return 6'd29;
      6'd52:   return 6'd40;
      6'd53:   return 6'd44;
      6'd55:   return 6'd55;
      6'd58:   return 6'd25;
      6'd59:   return 6'd47;
      6'd61:   return 6'd31;
      6'd62:   return 6'd62;
      default: return 6'd0;
    endcase
  endfunction

endpackage

### hw/rtl/hill_cipher_2x2_mod63.sv
// top level of the 2x2 hill cipher over a 63-symbol alphabet
// depends on hcm_pkg, hcm_front, hcm_queue, hcm_key, hcm_back
//
//   channel   handshake       payload
//   input     push / full     kind, in_char_0..3
//   result    empty / pop     out_char_0..3, status
//   config    wr_en           wr_index, wr_data
//
// one block per cycle sustained while results are popped; a taken block passes through
// the front register, a queue slot, the product stage and the result register
// full rises once the queue and the front register together hold QDEPTH blocks
// key derivation is a two-register chain that settles before a block taken
// after a key write reaches the product stage
// rst clears the key registers, the queue and all valid flags
module hill_cipher_2x2_mod63 #(
  parameter int QDEPTH = hcm_pkg::QDEPTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  logic                            kind,
  input  logic [hcm_pkg::CHAR_W-1:0]      in_char_0,
  input  logic [hcm_pkg::CHAR_W-1:0]      in_char_1,
  input  logic [hcm_pkg::CHAR_W-1:0]      in_char_2,
  input  logic [hcm_pkg::CHAR_W-1:0]      in_char_3,
  output logic                            empty,
  input  logic                            pop,
  output logic [hcm_pkg::CHAR_W-1:0]      out_char_0,
  output logic [hcm_pkg::CHAR_W-1:0]      out_char_1,
  output logic [hcm_pkg::CHAR_W-1:0]      out_char_2,
  output logic [hcm_pkg::CHAR_W-1:0]      out_char_3,
  output logic [hcm_pkg::STATUS_W-1:0]    status,
  input  logic                            wr_en,
  input  logic [hcm_pkg::REG_IDX_W-1:0]   wr_index,
  input  logic [hcm_pkg::CHAR_W-1:0]      wr_data
);
  import hcm_pkg::*;

  localparam int CW = $clog2(QDEPTH + 1);

  logic           f_valid;
  item_t          f_item;
  logic           q_pop;
  item_t          q_item;
  logic           q_empty;
  logic [CW-1:0]  q_count;
  key_t           key;

  hcm_front #(.QDEPTH(QDEPTH)) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .kind      (kind),
    .in_char_0 (in_char_0),
    .in_char_1 (in_char_1),
    .in_char_2 (in_char_2),
    .in_char_3 (in_char_3),
    .q_count   (q_count),
    .f_valid   (f_valid),
    .f_item    (f_item)
  );

  hcm_queue #(.QDEPTH(QDEPTH)) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (f_valid),
    .wr_item (f_item),
    .rd      (q_pop),
    .rd_item (q_item),
    .q_empty (q_empty),
    .count   (q_count)
  );

  hcm_key u_key (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .key      (key)
  );

  hcm_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .key        (key),
    .empty      (empty),
    .pop        (pop),
    .out_char_0 (out_char_0),
    .out_char_1 (out_char_1),
    .out_char_2 (out_char_2),
    .out_char_3 (out_char_3),
    .status     (status)
  );

  a_q_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= CW'(QDEPTH))
    else $error("queue count beyond depth");

  a_full_when_q_full: assert property (@(posedge clk) disable iff (rst)
    (q_count == CW'(QDEPTH)) |-> full)
    else $error("input taken with queue full");

  a_no_write_when_full: assert property (@(posedge clk) disable iff (rst)
    (f_valid && !q_pop) |-> (q_count != CW'(QDEPTH)))
    else $error("queue write would overflow");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && status != STATUS_OK) |->
      (out_char_0 == '0 && out_char_1 == '0 && out_char_2 == '0 && out_char_3 == '0))
    else $error("error result carries characters");

endmodule

### hw/rtl/hcm_front.sv
// front stage: accepts a block, maps characters to indices and flags bad symbols
// depends on hcm_pkg
module hcm_front #(
  parameter int QDEPTH = hcm_pkg::QDEPTH_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic                         kind,
  input  logic [hcm_pkg::CHAR_W-1:0]   in_char_0,
  input  logic [hcm_pkg::CHAR_W-1:0]   in_char_1,
  input  logic [hcm_pkg::CHAR_W-1:0]   in_char_2,
  input  logic [hcm_pkg::CHAR_W-1:0]   in_char_3,
  input  logic [$clog2(QDEPTH+1)-1:0]  q_count,
  output logic                         f_valid,
  output hcm_pkg::item_t               f_item
);
  import hcm_pkg::*;

  localparam int CW = $clog2(QDEPTH + 1);

  logic                 accept;
  logic [3:0][IDX_W:0]  ci;
  item_t                item_next;

  assign full   = ((CW+1)'(q_count) + (CW+1)'(f_valid)) >= (CW+1)'(QDEPTH);
  assign accept = push && !full;

  always_comb begin
    ci[0] = char_index(in_char_0);
    ci[1] = char_index(in_char_1);
    ci[2] = char_index(in_char_2);
    ci[3] = char_index(in_char_3);
    item_next.kind = kind;
    item_next.bad  = ci[0][IDX_W] | ci[1][IDX_W] | ci[2][IDX_W] | ci[3][IDX_W];
    for (int i = 0; i < 4; i++) begin
      item_next.p[i] = ci[i][IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else begin
      f_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_item <= item_next;
    end
  end

endmodule

### hw/rtl/hcm_queue.sv
// short queue of classified blocks between front and back
// depends on hcm_pkg
module hcm_queue #(
  parameter int QDEPTH = hcm_pkg::QDEPTH_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         wr,
  input  hcm_pkg::item_t               wr_item,
  input  logic                         rd,
  output hcm_pkg::item_t               rd_item,
  output logic                         q_empty,
  output logic [$clog2(QDEPTH+1)-1:0]  count
);
  import hcm_pkg::*;

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);

  item_t            slots [QDEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;

  function automatic logic [PW-1:0] bump(logic [PW-1:0] ptr);
    return (ptr == PW'(QDEPTH - 1)) ? '0 : ptr + 1'b1;
  endfunction

  assign q_empty = (count == '0);
  assign rd_item = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        wptr <= bump(wptr);
      end
      if (rd) begin
        rptr <= bump(rptr);
      end
      if (wr && !rd) begin
        count <= count + CW'(1);
      end else if (rd && !wr) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wptr] <= wr_item;
    end
  end

endmodule

### hw/rtl/hcm_key.sv
// key registers and the two-stage derivation of key indices and inverse matrix
// depends on hcm_pkg
module hcm_key (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wr_en,
  input  logic [hcm_pkg::REG_IDX_W-1:0]  wr_index,
  input  logic [hcm_pkg::CHAR_W-1:0]     wr_data,
  output hcm_pkg::key_t                  key
);
  import hcm_pkg::*;

  logic [3:0][CHAR_W-1:0] key_char;
  logic [3:0][IDX_W:0]    kc;
  idx_t [3:0]             kidx;
  logic                   kbad;
  idx_t                   det;
  logic [PROD_W-1:0]      p03;
  logic [PROD_W-1:0]      p12;
  logic [SUM_W-1:0]       det_raw;
  idx_t                   inv;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_char <= '0;
    end else if (wr_en) begin
      case (wr_index)
        REG_KEY_CHAR_0: key_char[0] <= wr_data;
        REG_KEY_CHAR_1: key_char[1] <= wr_data;
        REG_KEY_CHAR_2: key_char[2] <= wr_data;
        REG_KEY_CHAR_3: key_char[3] <= wr_data;
        default: ;
      endcase
    end
  end

  // first step: indices and determinant
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      kc[i] = char_index(key_char[i]);
    end
    p03     = PROD_W'(kc[0][IDX_W-1:0]) * PROD_W'(kc[3][IDX_W-1:0]);
    p12     = PROD_W'(kc[1][IDX_W-1:0]) * PROD_W'(kc[2][IDX_W-1:0]);
    det_raw = SUM_W'(p03) + SUM_W'(MOD * MOD) - SUM_W'(p12);
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      kidx[i] <= kc[i][IDX_W-1:0];
    end
    kbad <= kc[0][IDX_W] | kc[1][IDX_W] | kc[2][IDX_W] | kc[3][IDX_W];
    det  <= mod63(det_raw);
  end

  // second step: adjugate scaled by the determinant inverse
  assign inv = inv63(det);

  always_ff @(posedge clk) begin
    key.k        <= kidx;
    key.kbad     <= kbad;
    key.kinv_bad <= (inv == '0);
    key.minv[0]  <= mulmod(kidx[3], inv);
    key.minv[1]  <= mulmod(neg63(kidx[1]), inv);
    key.minv[2]  <= mulmod(neg63(kidx[2]), inv);
    key.minv[3]  <= mulmod(kidx[0], inv);
  end

endmodule

### hw/rtl/hcm_back.sv
// back part: matrix product stage and result register
// depends on hcm_pkg
module hcm_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_empty,
  input  hcm_pkg::item_t              q_item,
  output logic                        q_pop,
  input  hcm_pkg::key_t               key,
  output logic                        empty,
  input  logic                        pop,
  output logic [hcm_pkg::CHAR_W-1:0]  out_char_0,
  output logic [hcm_pkg::CHAR_W-1:0]  out_char_1,
  output logic [hcm_pkg::CHAR_W-1:0]  out_char_2,
  output logic [hcm_pkg::CHAR_W-1:0]  out_char_3,
  output logic [hcm_pkg::STATUS_W-1:0] status
);
  import hcm_pkg::*;

  logic                    adv;
  logic                    b1_valid;
  status_t                 b1_status;
  logic [7:0][PROD_W-1:0]  prod;
  idx_t [3:0]              m;
  status_t                 st;
  logic                    out_valid;
  idx_t [3:0]              r;
  logic [3:0][CHAR_W-1:0]  ch;

  assign adv   = !out_valid || pop;
  assign q_pop = adv && !q_empty;
  assign empty = !out_valid;

  always_comb begin
    m = (q_item.kind == KIND_DECRYPT) ? key.minv : key.k;
    if (q_item.bad || key.kbad) begin
      st = STATUS_BAD_CHAR;
    end else if (q_item.kind == KIND_DECRYPT && key.kinv_bad) begin
      st = STATUS_BAD_KEY;
    end else begin
      st = STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      b1_valid  <= !q_empty;
      out_valid <= b1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      b1_status <= st;
      prod[0]   <= PROD_W'(m[0]) * PROD_W'(q_item.p[0]);
      prod[1]   <= PROD_W'(m[1]) * PROD_W'(q_item.p[2]);
      prod[2]   <= PROD_W'(m[0]) * PROD_W'(q_item.p[1]);
      prod[3]   <= PROD_W'(m[1]) * PROD_W'(q_item.p[3]);
      prod[4]   <= PROD_W'(m[2]) * PROD_W'(q_item.p[0]);
      prod[5]   <= PROD_W'(m[3]) * PROD_W'(q_item.p[2]);
      prod[6]   <= PROD_W'(m[2]) * PROD_W'(q_item.p[1]);
      prod[7]   <= PROD_W'(m[3]) * PROD_W'(q_item.p[3]);
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      r[i]  = mod63(SUM_W'(prod[2*i]) + SUM_W'(prod[2*i+1]));
      ch[i] = (b1_status == STATUS_OK) ? index_char(r[i]) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && b1_valid) begin
      out_char_0 <= ch[0];
      out_char_1 <= ch[1];
      out_char_2 <= ch[2];
      out_char_3 <= ch[3];
      status     <= b1_status;
    end
  end

endmodule
